### src/avr3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avr3_pkg: shared types and constants for the 3D axis rotator
// Holds operation, axis and status codes, sizing constants and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package avr3_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int CORDIC_STEPS    = 24;
    localparam int TRIG_W          = 34;
    localparam int PHASE_W         = 32;
    localparam int FRAC_BITS       = 30;
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_CW   = 2'd1,
        OP_CCW  = 2'd2,
        OP_BAD  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        AX_X   = 2'd0,
        AX_Y   = 2'd1,
        AX_Z   = 2'd2,
        AX_BAD = 2'd3
    } t_axis;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BAD_OP = 2'd1,
        ST_BAD_AX = 2'd2,
        ST_RSVD   = 2'd3
    } t_status;

    // Arctangent of 2^-i, scaled so that a quarter turn is 2^30.
    function automatic logic signed [TRIG_W-1:0] atan_lut(input logic [4:0] idx);
        logic signed [TRIG_W-1:0] v;
        begin
            unique case (idx)
                5'd0:  v = 34'sd536870912;
                5'd1:  v = 34'sd316933406;
                5'd2:  v = 34'sd167458907;
                5'd3:  v = 34'sd85004756;
                5'd4:  v = 34'sd42667331;
                5'd5:  v = 34'sd21354465;
                5'd6:  v = 34'sd10679838;
                5'd7:  v = 34'sd5340245;
                5'd8:  v = 34'sd2670163;
                5'd9:  v = 34'sd1335087;
                5'd10: v = 34'sd667544;
                5'd11: v = 34'sd333772;
                5'd12: v = 34'sd166886;
                5'd13: v = 34'sd83443;
                5'd14: v = 34'sd41722;
                5'd15: v = 34'sd20861;
                5'd16: v = 34'sd10430;
                5'd17: v = 34'sd5215;
                5'd18: v = 34'sd2608;
                5'd19: v = 34'sd1304;
                5'd20: v = 34'sd652;
                5'd21: v = 34'sd326;
                5'd22: v = 34'sd163;
                5'd23: v = 34'sd81;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

### src/axis_vector_rotate_3d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_vector_rotate_3d: rotate a Q16.16 vector about X, Y or Z
// Front stage classifies each word, a CORDIC pipeline rotates it.
// ----------------------------------------------------------------------------
// Channel | Signals                                   | Direction
// in      | i_valid/o_ready, operation..in_z          | into block
// out     | o_valid/i_ready, out_x..status            | out of block
//
// One word per cycle while the output is not stalled; the path runs through the
// front register, a seed stage, 24 CORDIC stages, multiply, sum, round/saturate.
// Reset clears only valid bits. A stall at the output holds the whole
// pipeline; the front register keeps taking a word while a slot is free.
module axis_vector_rotate_3d
    import avr3_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_operation,
    input  logic [1:0]                    i_axis,
    input  logic [ANGLE_WIDTH-1:0]        i_angle,
    input  logic signed [COORD_WIDTH-1:0] i_in_x,
    input  logic signed [COORD_WIDTH-1:0] i_in_y,
    input  logic signed [COORD_WIDTH-1:0] i_in_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic signed [COORD_WIDTH-1:0] o_out_z,
    output logic [1:0]                    o_status
);

    logic                          f_valid, b_ready, f_rot;
    logic [1:0]                    f_axis, f_status;
    logic [PHASE_W-1:0]            f_phase;
    logic signed [COORD_WIDTH-1:0] f_x, f_y, f_z;

    avr3_front #(.COORD_WIDTH(COORD_WIDTH), .ANGLE_WIDTH(ANGLE_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_operation, .i_axis, .i_angle,
        .i_x(i_in_x), .i_y(i_in_y), .i_z(i_in_z),
        .o_valid(f_valid), .i_ready(b_ready), .o_rot(f_rot), .o_axis(f_axis),
        .o_status(f_status), .o_phase(f_phase), .o_x(f_x), .o_y(f_y), .o_z(f_z)
    );

    avr3_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_ready(b_ready),
        .i_rot(f_rot), .i_axis(f_axis), .i_status(f_status), .i_phase(f_phase),
        .i_x(f_x), .i_y(f_y), .i_z(f_z),
        .o_valid, .i_ready, .o_x(o_out_x), .o_y(o_out_y), .o_z(o_out_z), .o_status
    );

`ifndef SYNTHESIS
    // Status is never the reserved code.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status != ST_RSVD))
        else $error("reserved status delivered");
    // A stalled result keeps its x and z coordinates.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_out_x) && $stable(o_out_z)))
        else $error("stalled result changed");
    // With the output stage empty the block always takes a word.
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("front stalled with empty back");
`endif

endmodule

### src/avr3_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avr3_front: input stage and classifier
// Registers each accepted word, decides its status, and turns the angle into
// a 32-bit phase with the sign set by the rotation direction.
// ----------------------------------------------------------------------------
module avr3_front
    import avr3_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_operation,
    input  logic [1:0]                    i_axis,
    input  logic [ANGLE_WIDTH-1:0]        i_angle,
    input  logic signed [COORD_WIDTH-1:0] i_x,
    input  logic signed [COORD_WIDTH-1:0] i_y,
    input  logic signed [COORD_WIDTH-1:0] i_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_rot,
    output logic [1:0]                    o_axis,
    output logic [1:0]                    o_status,
    output logic [PHASE_W-1:0]            o_phase,
    output logic signed [COORD_WIDTH-1:0] o_x,
    output logic signed [COORD_WIDTH-1:0] o_y,
    output logic signed [COORD_WIDTH-1:0] o_z
);

    logic                   r_valid;
    logic                   n_rot;
    logic [1:0]             n_status;
    logic [PHASE_W-1:0]     n_phase;
    logic [PHASE_W-1:0]     w_ph;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;

    // Classify the word and form its phase.
    always_comb begin
        w_ph = {PHASE_W{1'b0}};
        w_ph[PHASE_W-1 -: ANGLE_WIDTH] = i_angle;
        n_phase  = (t_op'(i_operation) == OP_CW) ? (~w_ph + 1'b1) : w_ph;
        n_rot    = 1'b0;
        n_status = ST_OK;
        if (t_op'(i_operation) == OP_BAD) begin
            n_status = ST_BAD_OP;
        end else if (t_op'(i_operation) != OP_NONE) begin
            if (t_axis'(i_axis) == AX_BAD) begin
                n_status = ST_BAD_AX;
            end else begin
                n_rot = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            o_rot    <= n_rot;
            o_axis   <= i_axis;
            o_status <= n_status;
            o_phase  <= n_phase;
            o_x      <= i_x;
            o_y      <= i_y;
            o_z      <= i_z;
        end
    end

endmodule

### src/avr3_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avr3_back: pipelined CORDIC rotator
// One CORDIC step per stage gives sine and cosine, then a multiply stage, a
// sum stage and a round and saturate stage. The pipeline advances as a whole
// when its last stage is empty or is being taken.
// ----------------------------------------------------------------------------
module avr3_back
    import avr3_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_rot,
    input  logic [1:0]                    i_axis,
    input  logic [1:0]                    i_status,
    input  logic [PHASE_W-1:0]            i_phase,
    input  logic signed [COORD_WIDTH-1:0] i_x,
    input  logic signed [COORD_WIDTH-1:0] i_y,
    input  logic signed [COORD_WIDTH-1:0] i_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_x,
    output logic signed [COORD_WIDTH-1:0] o_y,
    output logic signed [COORD_WIDTH-1:0] o_z,
    output logic [1:0]                    o_status
);

    localparam int NS   = CORDIC_STEPS + 4;
    localparam int PW   = COORD_WIDTH + TRIG_W;
    localparam int SW   = PW + 1;
    localparam int RW   = SW - FRAC_BITS;

    typedef struct packed {
        logic                   rot;
        logic [1:0]             axis;
        logic [1:0]             status;
        logic [1:0]             quad;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
    } t_job;

    logic                     adv;
    logic [NS-1:0]            r_v;
    t_job                     r_job [NS-1];
    logic signed [TRIG_W-1:0] r_cx [CORDIC_STEPS+1];
    logic signed [TRIG_W-1:0] r_cy [CORDIC_STEPS+1];
    logic signed [TRIG_W-1:0] r_cz [CORDIC_STEPS+1];
    logic signed [PW-1:0]     r_p0, r_p1, r_p2, r_p3;
    logic signed [SW-1:0]     r_s0, r_s1;
    logic signed [COORD_WIDTH-1:0] r_ox, r_oy, r_oz;
    logic [1:0]               r_st;
    logic signed [TRIG_W-1:0]      w_c, w_s, w_fx, w_fy;
    logic signed [COORD_WIDTH-1:0] w_a, w_b;
    t_job                          w_j;
    t_job                          w_k;

    assign adv     = !r_v[NS-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_v[NS-1];
    assign o_x = r_ox;
    assign o_y = r_oy;
    assign o_z = r_oz;
    assign o_status = r_st;

    // Valid bits for every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [RW-1:0] t;
        logic signed [COORD_WIDTH-1:0] mx;
        begin
            t  = RW'(v >>> FRAC_BITS);
            mx = {1'b0, {(COORD_WIDTH-1){1'b1}}};
            if (t > RW'(mx)) return mx;
            if (t < RW'(~mx)) return ~mx;
            return COORD_WIDTH'(t);
        end
    endfunction

    // Quadrant fix-up and operand choice for the active plane.
    always_comb begin
        w_j  = r_job[CORDIC_STEPS];
        w_fx = r_cx[CORDIC_STEPS];
        w_fy = r_cy[CORDIC_STEPS];
        unique case (w_j.quad)
            2'd0:    begin w_c = w_fx;  w_s = w_fy;  end
            2'd1:    begin w_c = -w_fy; w_s = w_fx;  end
            2'd2:    begin w_c = -w_fx; w_s = -w_fy; end
            default: begin w_c = w_fy;  w_s = -w_fx; end
        endcase
        unique case (t_axis'(w_j.axis))
            AX_X:    begin w_a = w_j.y; w_b = w_j.z; end
            AX_Y:    begin w_a = w_j.z; w_b = w_j.x; end
            default: begin w_a = w_j.x; w_b = w_j.y; end
        endcase
    end

    assign w_k = r_job[CORDIC_STEPS+2];

    // Data pipeline: seed, micro-rotations, products, sums, round and place.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            // Stage 0 captures the job and seeds the CORDIC.
            r_job[0].rot    <= i_rot;
            r_job[0].axis   <= i_axis;
            r_job[0].status <= i_status;
            r_job[0].quad   <= i_phase[PHASE_W-1 -: 2];
            r_job[0].x      <= i_x;
            r_job[0].y      <= i_y;
            r_job[0].z      <= i_z;
            r_cx[0] <= CORDIC_GAIN_INV;
            r_cy[0] <= '0;
            r_cz[0] <= TRIG_W'({2'b00, i_phase[FRAC_BITS-1:0]});

            // One micro-rotation per stage.
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                r_job[i+1] <= r_job[i];
                if (!r_cz[i][TRIG_W-1]) begin
                    r_cx[i+1] <= r_cx[i] - (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] + (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] - atan_lut(5'(i));
                end else begin
                    r_cx[i+1] <= r_cx[i] + (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] - (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] + atan_lut(5'(i));
                end
            end

            // Products: a*c, b*s, a*s, b*c.
            r_job[CORDIC_STEPS+1] <= w_j;
            r_p0 <= PW'(w_a) * PW'(w_c);
            r_p1 <= PW'(w_b) * PW'(w_s);
            r_p2 <= PW'(w_a) * PW'(w_s);
            r_p3 <= PW'(w_b) * PW'(w_c);

            // Sums with rounding bias.
            r_job[CORDIC_STEPS+2] <= r_job[CORDIC_STEPS+1];
            r_s0 <= SW'(r_p0) - SW'(r_p1) + (SW'(1) <<< (FRAC_BITS-1));
            r_s1 <= SW'(r_p2) + SW'(r_p3) + (SW'(1) <<< (FRAC_BITS-1));

            // Round, saturate and place results.
            r_st <= w_k.status;
            r_ox <= w_k.x;
            r_oy <= w_k.y;
            r_oz <= w_k.z;
            if (w_k.rot) begin
                unique case (t_axis'(w_k.axis))
                    AX_X:    begin r_oy <= sat(r_s0); r_oz <= sat(r_s1); end
                    AX_Y:    begin r_oz <= sat(r_s0); r_ox <= sat(r_s1); end
                    default: begin r_ox <= sat(r_s0); r_oy <= sat(r_s1); end
                endcase
            end
        end
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 3D axis rotator
// Feeds directed corner vectors and random rotations through a valid/ready
// driver, predicts each result with a CORDIC model of its own, and compares
// every output word field by field under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top
    import avr3_pkg::*;
();

    localparam int CW = 32;
    localparam int AW = 16;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic [1:0]           op;
        logic [1:0]           ax;
        logic [AW-1:0]        ang;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_job;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [1:0]           st;
    } t_vec_out;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic [1:0] i_operation = '0;
    logic [1:0] i_axis = '0;
    logic [AW-1:0] i_angle = '0;
    logic signed [CW-1:0] i_in_x = '0, i_in_y = '0, i_in_z = '0;
    logic o_ready, o_valid;
    logic signed [CW-1:0] o_out_x, o_out_y, o_out_z;
    logic [1:0] o_status;

    t_job     pending_jobs[$];
    t_vec_out rotated_vecs[$];
    int  n_errors = 0;
    int  n_sent = 0;
    int  n_checked = 0;
    int  n_cycles = 0;
    bit  stim_done = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_off = 0;

    axis_vector_rotate_3d i_dut (.*);

    // Clock: 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sine and cosine in Q2.30 from a 24-step rotation CORDIC.
    function automatic void trig_of_phase(input logic [31:0] ph,
                                          output longint c, output longint s);
        longint cx, cy, cz, nx;
        cx = 652032874;
        cy = 0;
        cz = longint'(ph[29:0]);
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (cz >= 0) begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                cz = cz - longint'(atan_lut(i[4:0]));
            end else begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                cz = cz + longint'(atan_lut(i[4:0]));
            end
            cx = nx;
        end
        case (ph[31:30])
            2'd0: begin c = cx;  s = cy;  end
            2'd1: begin c = -cy; s = cx;  end
            2'd2: begin c = -cx; s = -cy; end
            default: begin c = cy; s = -cx; end
        endcase
    endfunction

    // Exact a*c + b*s (Q2.30 trig), rounded half up at bit 30, saturated.
    function automatic logic signed [CW-1:0] mix_round_sat(
        input longint a, input longint c, input longint b, input longint s);
        logic signed [127:0] acc;
        logic signed [127:0] q;
        acc = 128'(signed'(a)) * 128'(signed'(c)) + 128'(signed'(b)) * 128'(signed'(s));
        q = (acc + (128'sd1 <<< 29)) >>> 30;
        if (q > 128'sd2147483647) return 32'sh7fffffff;
        if (q < -128'sd2147483648) return 32'sh80000000;
        return q[CW-1:0];
    endfunction

    function automatic t_vec_out rotate_vector(input t_job j);
        t_vec_out r;
        logic [31:0] ph;
        longint c, s, x, y, z;
        r.x = j.x; r.y = j.y; r.z = j.z; r.st = ST_OK;
        x = j.x; y = j.y; z = j.z;
        if (j.op == OP_BAD) begin
            r.st = ST_BAD_OP;
        end else if (j.op != OP_NONE && j.ax == AX_BAD) begin
            r.st = ST_BAD_AX;
        end else if (j.op != OP_NONE) begin
            ph = {j.ang, 16'd0};
            // Clockwise runs the angle backwards.
            if (j.op == OP_CW) ph = 32'd0 - ph;
            trig_of_phase(ph, c, s);
            case (j.ax)
                AX_X: begin
                    r.y = mix_round_sat(y, c, z, -s);
                    r.z = mix_round_sat(y, s, z, c);
                end
                AX_Y: begin
                    r.z = mix_round_sat(z, c, x, -s);
                    r.x = mix_round_sat(z, s, x, c);
                end
                default: begin
                    r.x = mix_round_sat(x, c, y, -s);
                    r.y = mix_round_sat(x, s, y, c);
                end
            endcase
        end
        return r;
    endfunction

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            1: return CW'($signed($urandom_range(0, 65535 * 20)) - 65536 * 10);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_job(input t_op op, input t_axis ax, input int ang,
                           input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                           input logic signed [CW-1:0] z);
        t_job j;
        j.op = op; j.ax = ax; j.ang = AW'(ang); j.x = x; j.y = y; j.z = z;
        pending_jobs.push_back(j);
    endtask

    // Stimulus: directed corners first, then random words.
    initial begin
        t_job j;
        int r;
        add_job(OP_NONE, AX_BAD, 16'h1234, 32'sh7fffffff, 32'sh80000000, 1);
        add_job(OP_BAD, AX_X, 0, 5, 6, 7);
        add_job(OP_BAD, AX_BAD, 16'hffff, -1, -2, -3);
        add_job(OP_CW, AX_BAD, 100, 11, 12, 13);
        add_job(OP_CCW, AX_BAD, 100, 11, 12, 13);
        for (int a = 0; a < 3; a++) begin
            add_job(OP_CCW, t_axis'(a), 0, 32'h10000, 32'h20000, 32'h30000);
            add_job(OP_CCW, t_axis'(a), 16'h4000, 32'h10000, 32'h20000, 32'h30000);
            add_job(OP_CW, t_axis'(a), 16'h8000, 32'h10000, 32'h20000, 32'h30000);
            add_job(OP_CW, t_axis'(a), 16'hffff, 32'sh7fffffff, 32'sh7fffffff,
                    32'sh7fffffff);
            add_job(OP_CCW, t_axis'(a), 16'h2000, 32'sh80000000, 32'sh80000000,
                    32'sh80000000);
            add_job(OP_CW, t_axis'(a), 16'h2000, 32'sh7fffffff, 32'sh80000000, 0);
        end
        add_job(OP_CCW, AX_Z, 16'hc000, 0, 0, 0);
        add_job(OP_CW, AX_Z, 16'h0001, -1, -1, -1);
        for (int k = 0; k < 1500; k++) begin
            r = $urandom_range(0, 99);
            j.op = (r < 85) ? ($urandom_range(0, 1) ? OP_CW : OP_CCW) : 2'($urandom);
            j.ax = ($urandom_range(0, 9) == 0) ? AX_BAD : 2'($urandom_range(0, 2));
            j.ang = AW'($urandom);
            j.x = rand_coord(); j.y = rand_coord(); j.z = rand_coord();
            pending_jobs.push_back(j);
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_jobs.size() == 0 && !i_valid);
        stim_done = 1'b1;
    end

    // Driver: holds each word until accepted, random gaps between words.
    always @(posedge i_clk) begin
        t_job j;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                rotated_vecs.push_back(rotate_vector(
                    {i_operation, i_axis, i_angle, i_in_x, i_in_y, i_in_z}));
                n_sent <= n_sent + 1;
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    i_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_jobs.size() > 0) begin
                    j = pending_jobs.pop_front();
                    i_valid <= 1'b1;
                    i_operation <= j.op; i_axis <= j.ax; i_angle <= j.ang;
                    i_in_x <= j.x; i_in_y <= j.y; i_in_z <= j.z;
                    send_gap <= pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random ready, plus one long hold-off mid-run to fill the pipe.
    always @(posedge i_clk) begin
        t_vec_out e;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (rotated_vecs.size() == 0) begin
                    $error("unexpected output word");
                    n_errors++;
                end else begin
                    e = rotated_vecs.pop_front();
                    n_checked++;
                    if (o_out_x !== e.x) begin
                        $error("out_x expected %0d actual %0d", e.x, o_out_x); n_errors++;
                    end
                    if (o_out_y !== e.y) begin
                        $error("out_y expected %0d actual %0d", e.y, o_out_y); n_errors++;
                    end
                    if (o_out_z !== e.z) begin
                        $error("out_z expected %0d actual %0d", e.z, o_out_z); n_errors++;
                    end
                    if (o_status !== e.st) begin
                        $error("status expected %0d actual %0d", e.st, o_status); n_errors++;
                    end
                end
            end
            if (n_sent == 300 && hold_off == 0) begin
                hold_off <= 200;
                i_ready <= 1'b0;
            end else if (hold_off > 1) begin
                hold_off <= hold_off - 1;
            end else if (hold_off == 1) begin
                hold_off <= -1;
                i_ready <= 1'b1;
            end else if (recv_gap > 0) begin
                i_ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                i_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // End of run: drain, settle, report.
    initial begin
        wait (stim_done && rotated_vecs.size() == 0);
        repeat (60) @(posedge i_clk);
        $display("Covered %0d words (%0d checked): all ops and axes, saturating corners,",
                 n_sent, n_checked);
        $display("random stalls on both sides and one long output hold-off.");
        if (n_errors == 0 && rotated_vecs.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
